[src/asa_pkg.sv]
// shared types, constants and helpers for the adc scan averager
package asa_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_MUX_LIST      = 2'd1,
    CFG_AVG_LOG2      = 2'd2
  } cfg_idx_t;

  // item kinds
  typedef enum logic {
    MODE_CONV = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned MUX_W      = 5;
  localparam int unsigned MUX_LIST_W = 40;
  localparam int unsigned CH_CNT_W   = 4;
  localparam int unsigned AVG_W      = 3;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned CH_CMP_W   = 6;

  localparam logic [AVG_W-1:0]      AVG_LOG2_MAX     = 3'd6;
  localparam logic [CH_CNT_W-1:0]   CH_CNT_RESET     = 4'd1;
  localparam logic [AVG_W-1:0]      AVG_LOG2_RESET   = 3'd2;
  localparam logic [MUX_W-1:0]      MUX_FIELD_MASK   = 5'd31;

  // what one accepted word leaves behind in the scan logic
  typedef struct packed {
    logic                stored_flag;
    logic [SLOT_W-1:0]   stored_slot;
    logic [SAMPLE_W-1:0] stored_value;
    logic [MUX_W-1:0]    mux_code;
  } scan_rpt_t;

  // mux code of one of the eight packed slots
  function automatic logic [MUX_W-1:0] mux_pick(input logic [MUX_LIST_W-1:0] list,
                                                input logic [2:0] idx);
    logic [5:0] lsb;
    lsb = 6'(idx) * 6'd5;
    return list[lsb +: MUX_W] & MUX_FIELD_MASK;
  endfunction

endpackage

[src/adc_scan_averager_unit.sv]
// top level of the adc scan averager: config registers, average store and output pipeline
//
// The unit walks a list of converter mux codes round robin. Every conversion word adds its
// sample to an accumulator; after 2^k samples (k is avg_log2, capped at 6) the sum shifted
// right by k is stored as the current slot's average, the accumulator clears and the scan
// moves to the next slot (wrapping after channel_count slots). A read word returns a slot's
// stored average. Every accepted word gives exactly one result word, which also carries the
// mux code of the slot to be sampled next. The unit takes one word per clock while the
// output side is ready; a stalled output register holds stage 1 and so stops the input.
// An accepted word passes through stage 1 and the output register. The averages sit in a
// small ram with a registered read; a per-slot valid bit, cleared by reset, makes
// never-written slots read as zero, so no clearing pass is needed. An average written by one
// word is visible to a read word accepted on the very next cycle. Configuration registers
// are written with cfg_wr_en and take effect at once; write them only while the unit is idle.
module adc_scan_averager_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_index,
  input  logic [asa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [asa_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic [asa_pkg::SLOT_W-1:0]         in_slot,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [asa_pkg::SAMPLE_W-1:0]       out_read_value,
  output logic [asa_pkg::MUX_W-1:0]          out_mux_code,
  output logic                               out_stored_flag,
  output logic [asa_pkg::SLOT_W-1:0]         out_stored_slot,
  output logic [asa_pkg::SAMPLE_W-1:0]       out_stored_value
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned XW = (SW > asa_pkg::SLOT_W) ? SW : asa_pkg::SLOT_W;

  // configuration registers
  logic [asa_pkg::CH_CNT_W-1:0]   ch_cnt_r;
  logic [asa_pkg::MUX_LIST_W-1:0] mux_list_r;
  logic [asa_pkg::AVG_W-1:0]      avg_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r   <= asa_pkg::CH_CNT_RESET;
      mux_list_r <= '0;
      avg_log2_r <= asa_pkg::AVG_LOG2_RESET;
    end else if (cfg_wr_en) begin
      case (asa_pkg::cfg_idx_t'(cfg_index))
        asa_pkg::CFG_CHANNEL_COUNT: ch_cnt_r   <= cfg_wdata[asa_pkg::CH_CNT_W-1:0];
        asa_pkg::CFG_MUX_LIST:      mux_list_r <= cfg_wdata[asa_pkg::MUX_LIST_W-1:0];
        asa_pkg::CFG_AVG_LOG2:      avg_log2_r <= cfg_wdata[asa_pkg::AVG_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // handshake and pipeline control
  logic accept, conv_go, rd_go;
  logic s1_v_r, s1_move;
  logic out_v_r;

  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_move;
  assign accept   = in_valid && in_ready;
  assign conv_go  = accept && (asa_pkg::mode_t'(in_mode) == asa_pkg::MODE_CONV);
  assign rd_go    = accept && (asa_pkg::mode_t'(in_mode) == asa_pkg::MODE_READ);

  // scan state: accumulate, count, store, advance
  asa_pkg::scan_rpt_t           rpt;
  logic                         wr_en;
  logic [SW-1:0]                wr_addr;
  logic [asa_pkg::SAMPLE_W-1:0] wr_data;

  asa_scan #(
    .SLOTS(SLOTS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (conv_go),
    .sample        (in_sample),
    .channel_count (ch_cnt_r),
    .mux_list      (mux_list_r),
    .avg_log2      (avg_log2_r),
    .rpt           (rpt),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  // average store; read issued at accept, data registered by the ram in the following cycle
  logic [SW-1:0]                rd_addr;
  logic [asa_pkg::SAMPLE_W-1:0] rd_data;
  logic [XW:0]                  slot_x;
  logic                         slot_ok;
  logic [SLOTS-1:0]             valid_r;
  logic                         rd_hit;

  // one spare bit so the slot count itself fits in the compare
  assign slot_x  = (XW+1)'(in_slot);
  assign slot_ok = slot_x < (XW+1)'(SLOTS);
  assign rd_addr = SW'(in_slot);
  // never-written or out-of-range slots read as zero
  assign rd_hit  = rd_go && slot_ok && valid_r[rd_addr];

  asa_ram #(
    .WIDTH(asa_pkg::SAMPLE_W),
    .DEPTH(SLOTS)
  ) u_avg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_go),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // stage 1: word accepted, ram read in flight
  asa_pkg::scan_rpt_t s1_rpt_r;
  logic               s1_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rpt_r <= rpt;
      s1_hit_r <= rd_hit;
    end
  end

  // output register; ram data holds while stage 1 waits since no new read is issued
  asa_pkg::scan_rpt_t           out_rpt_r;
  logic [asa_pkg::SAMPLE_W-1:0] out_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_rpt_r <= s1_rpt_r;
      out_rd_r  <= s1_hit_r ? rd_data : '0;
    end
  end

  assign out_valid        = out_v_r;
  assign out_read_value   = out_rd_r;
  assign out_mux_code     = out_rpt_r.mux_code;
  assign out_stored_flag  = out_rpt_r.stored_flag;
  assign out_stored_slot  = out_rpt_r.stored_slot;
  assign out_stored_value = out_rpt_r.stored_value;

  // a stored average marks its slot valid for the following reads
  a_store_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_addr)])
    else $error("stored slot not marked valid");

  // stage 1 only blocks input when the output register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // a result that stores an average never carries a read value
  a_flag_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stored_flag) |-> (out_read_value == '0))
    else $error("stored word carries a read value");

  // only conversion words write the store
  a_write_on_conv: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> conv_go)
    else $error("store written without a conversion word");

endmodule

[src/asa_ram.sv]
// generic single-write, single-read ram with registered read data
module asa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/asa_scan.sv]
// accumulator, sample counter and scan slot walker
module asa_scan #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     step,
  input  logic [asa_pkg::SAMPLE_W-1:0]             sample,
  input  logic [asa_pkg::CH_CNT_W-1:0]             channel_count,
  input  logic [asa_pkg::MUX_LIST_W-1:0]           mux_list,
  input  logic [asa_pkg::AVG_W-1:0]                avg_log2,
  output asa_pkg::scan_rpt_t                       rpt,
  output logic                                     wr_en,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  output logic [asa_pkg::SAMPLE_W-1:0]             wr_data
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned XW = (SW > 3) ? SW : 3;

  logic [asa_pkg::ACC_W-1:0]    acc_r, acc_nxt, acc_sum;
  logic [asa_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc, thresh;
  logic [SW-1:0]                slot_r, slot_nxt;
  logic [asa_pkg::AVG_W-1:0]    k_eff;
  logic [asa_pkg::CH_CMP_W-1:0] ch_x, ch_eff, slot_inc;
  logic [asa_pkg::SAMPLE_W-1:0] avg;
  logic                         done;
  logic [XW-1:0]                mux_slot;

  always_comb begin
    k_eff   = (avg_log2 > asa_pkg::AVG_LOG2_MAX) ? asa_pkg::AVG_LOG2_MAX : avg_log2;
    acc_sum = acc_r + asa_pkg::ACC_W'(sample);
    cnt_inc = cnt_r + asa_pkg::CNT_W'(1);
    thresh  = asa_pkg::CNT_W'(1) << k_eff;
    done    = cnt_inc >= thresh;
    avg     = asa_pkg::SAMPLE_W'(acc_sum >> k_eff);

    // effective channel count, one to SLOTS
    ch_x = asa_pkg::CH_CMP_W'(channel_count);
    if (ch_x == '0) begin
      ch_eff = asa_pkg::CH_CMP_W'(1);
    end else if (ch_x > asa_pkg::CH_CMP_W'(SLOTS)) begin
      ch_eff = asa_pkg::CH_CMP_W'(SLOTS);
    end else begin
      ch_eff = ch_x;
    end
    slot_inc = asa_pkg::CH_CMP_W'(slot_r) + asa_pkg::CH_CMP_W'(1);

    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    if (step) begin
      if (done) begin
        acc_nxt  = '0;
        cnt_nxt  = '0;
        slot_nxt = (slot_inc >= ch_eff) ? '0 : SW'(slot_inc);
      end else begin
        acc_nxt = acc_sum;
        cnt_nxt = cnt_inc;
      end
    end

    wr_en   = step && done;
    wr_addr = slot_r;
    wr_data = avg;

    // slots past the packed list have mux code zero
    mux_slot = XW'(slot_nxt);
    rpt.stored_flag  = step && done;
    rpt.stored_slot  = (step && done) ? asa_pkg::SLOT_W'(slot_r) : '0;
    rpt.stored_value = (step && done) ? avg : '0;
    rpt.mux_code     = ((mux_slot >> 3) == '0) ? asa_pkg::mux_pick(mux_list, mux_slot[2:0])
                                                : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule
